FILE: hdl/mandelbrot_escape_time_assert.svh
// Assertion macros shared by the escape-time RTL.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`ifndef SYNTHESIS
`define MET_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed: %m");
`define MET_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed: %m");
`else
`define MET_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons)
`define MET_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

FILE: hdl/met_pkg.sv
// Types, constants and helpers for the escape-time unit.
// Used by met_ctrl, met_dp and mandelbrot_escape_time; no dependencies.
package met_pkg;

  localparam int FRAC_BITS_DEF = 28;
  localparam int HW = 32;           // half of a z component, one multiplier operand
  localparam int ZW = 64;           // z and c component width
  localparam int PW = 128;          // exact product width
  localparam int KW = 17;           // step counter, holds limit + 1
  localparam int CMW = 45;          // pixel index times step

  // configuration register indexes
  localparam logic [2:0] IDX_RE_START    = 3'd0;
  localparam logic [2:0] IDX_IM_START    = 3'd1;
  localparam logic [2:0] IDX_RE_STEP     = 3'd2;
  localparam logic [2:0] IDX_IM_STEP     = 3'd3;
  localparam logic [2:0] IDX_MAX_ITER    = 3'd4;
  localparam logic [2:0] IDX_WINDOW_LEFT = 3'd5;
  localparam logic [2:0] IDX_WINDOW_TOP  = 3'd6;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
  } pixel_t;

  typedef struct packed {
    logic [12:0] screen_x;
    logic [12:0] screen_y;
    logic [15:0] escape_count;
  } result_t;

  typedef struct packed {
    logic signed [31:0] re_start;
    logic signed [31:0] im_start;
    logic signed [31:0] re_step;
    logic signed [31:0] im_step;
    logic [15:0]        max_iterations;
    logic [11:0]        window_left;
    logic [11:0]        window_top;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    re_start:       -32'sd671088640,
    im_start:       -32'sd402653184,
    re_step:        32'sd3355443,
    im_step:        32'sd3355443,
    max_iterations: 16'd255,
    window_left:    12'd0,
    window_top:     12'd0
  };

  // controller to datapath: one strobe per phase
  typedef struct packed {
    logic capture;   // latch the pixel word
    logic cmul;      // index times step
    logic cinit;     // c = start + product, z = c, count = 1
    logic sq;        // partial products of z
    logic full;      // combine partials
    logic sum;       // |z|^2, difference of squares, signed cross term
    logic step;      // escape test, next z
  } cmd_t;

  typedef struct packed {
    logic finish;    // escaped or over the limit
  } status_t;

  function automatic logic [ZW-1:0] mag(input logic [ZW-1:0] x);
    mag = x[ZW-1] ? (~x + {{(ZW-1){1'b0}}, 1'b1}) : x;
  endfunction

endpackage

FILE: hdl/met_ctrl.sv
// Sequencer for the escape-time unit: one-hot state machine.
// Depends on met_pkg (cmd_t, status_t).
module met_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  met_pkg::status_t status,
  output met_pkg::cmd_t    cmd,
  output logic             busy
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CMUL  = 7'b0000010,
    ST_CINIT = 7'b0000100,
    ST_SQ    = 7'b0001000,
    ST_FULL  = 7'b0010000,
    ST_SUM   = 7'b0100000,
    ST_STEP  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_CMUL;
      ST_CMUL:  state_next = ST_CINIT;
      ST_CINIT: state_next = ST_SQ;
      ST_SQ:    state_next = ST_FULL;
      ST_FULL:  state_next = ST_SUM;
      ST_SUM:   state_next = ST_STEP;
      ST_STEP:  state_next = status.finish ? ST_IDLE : ST_SQ;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign busy        = (state != ST_IDLE);
  assign cmd.capture = (state == ST_IDLE) && start;
  assign cmd.cmul    = (state == ST_CMUL);
  assign cmd.cinit   = (state == ST_CINIT);
  assign cmd.sq      = (state == ST_SQ);
  assign cmd.full    = (state == ST_FULL);
  assign cmd.sum     = (state == ST_SUM);
  assign cmd.step    = (state == ST_STEP);

endmodule

FILE: hdl/met_dp.sv
// Fixed-point datapath for the escape-time unit: c formation, split
// 64x64 squaring on 32x32 multipliers, escape test. Depends on met_pkg.
module met_dp #(
  parameter int FRAC_BITS = met_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  met_pkg::cmd_t     cmd,
  input  met_pkg::cfg_t     cfg,
  input  met_pkg::pixel_t   pixel,
  output met_pkg::status_t  status,
  output met_pkg::result_t  result,
  output logic              result_valid
);

  localparam int HW  = met_pkg::HW;
  localparam int ZW  = met_pkg::ZW;
  localparam int PW  = met_pkg::PW;
  localparam int KW  = met_pkg::KW;
  localparam int CMW = met_pkg::CMW;
  // escape when |z|^2 > 4.0, compared exactly at 2*FRAC_BITS fraction bits
  localparam logic [PW-1:0] THR = {{(PW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

  logic [11:0]           col, row;
  logic signed [CMW-1:0] cm_re, cm_im;
  logic [ZW-1:0]         cr, ci, zr, zi;
  logic [KW-1:0]         k;
  logic                  neg;
  logic [2*HW-1:0]       rr_ll, rr_lh, rr_hh, ii_ll, ii_lh, ii_hh;
  logic [2*HW-1:0]       x_ll, x_hl, x_lh, x_hh;
  logic [PW-1:0]         sr, si, p;
  logic [PW-1:0]         rsum, diff, ps;
  logic [ZW-1:0]         ar, ai;
  logic                  finish;

  assign ar = met_pkg::mag(zr);
  assign ai = met_pkg::mag(zi);

  assign finish        = (rsum > THR) || (k > {1'b0, cfg.max_iterations});
  assign status.finish = finish;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col <= pixel.column;
      row <= pixel.row;
    end
    if (cmd.cmul) begin
      cm_re <= $signed({1'b0, col}) * cfg.re_step;
      cm_im <= $signed({1'b0, row}) * cfg.im_step;
    end
    if (cmd.cinit) begin
      // first step from z = 0 lands exactly on c
      cr <= {{(ZW-32){cfg.re_start[31]}}, cfg.re_start} + {{(ZW-CMW){cm_re[CMW-1]}}, cm_re};
      ci <= {{(ZW-32){cfg.im_start[31]}}, cfg.im_start} + {{(ZW-CMW){cm_im[CMW-1]}}, cm_im};
      zr <= {{(ZW-32){cfg.re_start[31]}}, cfg.re_start} + {{(ZW-CMW){cm_re[CMW-1]}}, cm_re};
      zi <= {{(ZW-32){cfg.im_start[31]}}, cfg.im_start} + {{(ZW-CMW){cm_im[CMW-1]}}, cm_im};
      k  <= {{(KW-1){1'b0}}, 1'b1};
    end
    if (cmd.sq) begin
      rr_ll <= ar[HW-1:0]    * ar[HW-1:0];
      rr_lh <= ar[ZW-1:HW]   * ar[HW-1:0];
      rr_hh <= ar[ZW-1:HW]   * ar[ZW-1:HW];
      ii_ll <= ai[HW-1:0]    * ai[HW-1:0];
      ii_lh <= ai[ZW-1:HW]   * ai[HW-1:0];
      ii_hh <= ai[ZW-1:HW]   * ai[ZW-1:HW];
      x_ll  <= ar[HW-1:0]    * ai[HW-1:0];
      x_hl  <= ar[ZW-1:HW]   * ai[HW-1:0];
      x_lh  <= ar[HW-1:0]    * ai[ZW-1:HW];
      x_hh  <= ar[ZW-1:HW]   * ai[ZW-1:HW];
      neg   <= zr[ZW-1] ^ zi[ZW-1];
    end
    if (cmd.full) begin
      // square: cross term appears twice, hence the shift by HW+1
      sr <= {rr_hh, rr_ll} + {{(HW-1){1'b0}}, rr_lh, {(HW+1){1'b0}}};
      si <= {ii_hh, ii_ll} + {{(HW-1){1'b0}}, ii_lh, {(HW+1){1'b0}}};
      p  <= {x_hh, x_ll} + {{HW{1'b0}}, x_hl, {HW{1'b0}}}
                         + {{HW{1'b0}}, x_lh, {HW{1'b0}}};
    end
    if (cmd.sum) begin
      rsum <= sr + si;
      diff <= sr - si;
      ps   <= neg ? (~p + {{(PW-1){1'b0}}, 1'b1}) : p;
    end
    if (cmd.step && !finish) begin
      // floor shifts; 2*zr*zi drops one bit less
      zr <= diff[FRAC_BITS + ZW - 1 -: ZW] + cr;
      zi <= ps[FRAC_BITS + ZW - 2 -: ZW] + ci;
      k  <= k + {{(KW-1){1'b0}}, 1'b1};
    end
    if (cmd.step && finish) begin
      result.screen_x     <= {1'b0, col} + {1'b0, cfg.window_left};
      result.screen_y     <= {1'b0, row} + {1'b0, cfg.window_top};
      result.escape_count <= (k > {1'b0, cfg.max_iterations}) ? 16'd0 : k[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.step && finish;
    end
  end

endmodule

FILE: hdl/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time unit: configuration registers,
// sequencer and datapath. Depends on met_pkg, met_ctrl, met_dp and the assert header.
//
// Usage:
//   Configuration: wr_en/wr_index/wr_data write one register per clock, no
//   wait. Index 0..6 = re_start, im_start, re_step, im_step (signed Q4.28),
//   max_iterations, window_left, window_top; other indexes are ignored.
//   Write only while busy is low and no result is pending.
//   Input: a pixel word (column, row) is taken on a rising edge with start
//   high and busy low. busy stays high until the result is produced.
//   Output: result_valid pulses for one cycle with screen_x, screen_y and
//   escape_count (0 when the point never escaped). The receiver cannot stall;
//   the word is gone after that cycle.
//   Sequence: each iteration of z = z*z + c passes the states multiply
//   partials, combine, sum and test/update, on ten 32x32 multipliers, after
//   an index multiply and c formation; it repeats until escape, or until
//   limit + 1 steps for a point that never escapes. A new word can be taken
//   while result_valid is high, never before the last word is done.
//   Reset: rst (synchronous) loads the default window (-2.5, -1.5, step
//   0.0125, limit 255, origin 0,0), idles the sequencer, drops result_valid.
`include "mandelbrot_escape_time_assert.svh"

module mandelbrot_escape_time #(
  parameter int FRAC_BITS = met_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // pixel word channel
  input  logic              start,
  input  met_pkg::pixel_t   pixel,
  output logic              busy,
  // result word channel
  output logic              result_valid,
  output met_pkg::result_t  result,
  // configuration write port
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [31:0]       wr_data
);

  met_pkg::cfg_t    cfg;
  met_pkg::cmd_t    cmd;
  met_pkg::status_t status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= met_pkg::CFG_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        met_pkg::IDX_RE_START:    cfg.re_start       <= wr_data;
        met_pkg::IDX_IM_START:    cfg.im_start       <= wr_data;
        met_pkg::IDX_RE_STEP:     cfg.re_step        <= wr_data;
        met_pkg::IDX_IM_STEP:     cfg.im_step        <= wr_data;
        met_pkg::IDX_MAX_ITER:    cfg.max_iterations <= wr_data[15:0];
        met_pkg::IDX_WINDOW_LEFT: cfg.window_left    <= wr_data[11:0];
        met_pkg::IDX_WINDOW_TOP:  cfg.window_top     <= wr_data[11:0];
        default: ;
      endcase
    end
  end

  // sequencer: one state per datapath phase
  met_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // arithmetic and result register
  met_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg          (cfg),
    .pixel        (pixel),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

  // result is shown only once the sequencer is back to idle
  `MET_ASSERT_IMPLY(a_valid_idle, clk, rst, result_valid, !busy)
  // an accepted word always starts work
  `MET_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // one pulse per word, never two in a row
  `MET_ASSERT_NEXT(a_single_pulse, clk, rst, result_valid, !result_valid)
  // a reported count never exceeds the limit
  `MET_ASSERT_IMPLY(a_count_limit, clk, rst, result_valid,
                    result.escape_count <= cfg.max_iterations)

endmodule

FILE: tb/sv/tb_mandelbrot_escape_time.sv
// Self-checking testbench for mandelbrot_escape_time: pixel words in, escape words out.
// A bit-exact escape-time predictor checks every result; depends on met_pkg and the RTL.
`timescale 1ns / 100ps

module tb_mandelbrot_escape_time;

  localparam int FRAC = met_pkg::FRAC_BITS_DEF;
  // |z|^2 threshold: 4.0 at the scale of a full product
  localparam logic [127:0] ESCAPE_RADIUS2 = 128'd1 << (2 * FRAC + 2);
  localparam logic [2:0] IDX_UNUSED = 3'd7;   // not a register, writes are dropped
  localparam int MAX_REPORTS = 10;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  met_pkg::pixel_t  pixel = '0;
  logic             busy;
  logic             result_valid;
  met_pkg::result_t result;
  logic             wr_en = 1'b0;
  logic [2:0]       wr_index = '0;
  logic [31:0]      wr_data = '0;

  // window settings as the block should hold them
  met_pkg::cfg_t    window_cfg = met_pkg::CFG_RESET;

  met_pkg::pixel_t  pending_pixels[$];
  met_pkg::result_t expected_escapes[$];
  int               words_sent = 0;
  int               bad_words = 0;
  met_pkg::result_t want;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mandelbrot_escape_time u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .pixel        (pixel),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  // Escape-time iteration at full width: c exact in 64 bits, squares exact in
  // 128 bits, each new component is a floor shift of the product plus c.
  function automatic met_pkg::result_t predict_escape(met_pkg::pixel_t px);
    logic signed [63:0]  base, incr, c_re, c_im, z_re, z_im;
    logic signed [127:0] w_re, w_im, sq_re, sq_im, zz_prod, shifted;
    logic [127:0]        mag2;
    int unsigned         steps;
    met_pkg::result_t    r;
    base = {{32{window_cfg.re_start[31]}}, window_cfg.re_start};
    incr = {{32{window_cfg.re_step[31]}}, window_cfg.re_step};
    c_re = base + $signed({52'd0, px.column}) * incr;
    base = {{32{window_cfg.im_start[31]}}, window_cfg.im_start};
    incr = {{32{window_cfg.im_step[31]}}, window_cfg.im_step};
    c_im = base + $signed({52'd0, px.row}) * incr;
    z_re = '0;
    z_im = '0;
    sq_re = '0;
    sq_im = '0;
    steps = 0;
    do begin
      w_re = z_re;
      w_im = z_im;
      zz_prod = w_re * w_im;
      shifted = (sq_re - sq_im) >>> FRAC;
      z_re = shifted[63:0] + c_re;
      shifted = zz_prod >>> (FRAC - 1);     // 2*zr*zi
      z_im = shifted[63:0] + c_im;
      w_re = z_re;
      w_im = z_im;
      sq_re = w_re * w_re;
      sq_im = w_im * w_im;
      mag2 = sq_re + sq_im;
      steps++;
    end while (mag2 <= ESCAPE_RADIUS2 && steps <= window_cfg.max_iterations);
    r.screen_x = {1'b0, px.column} + {1'b0, window_cfg.window_left};
    r.screen_y = {1'b0, px.row} + {1'b0, window_cfg.window_top};
    // ran past the limit: the point is taken as inside the set
    r.escape_count = (steps > window_cfg.max_iterations) ? 16'd0 : steps[15:0];
    return r;
  endfunction

  // Driver: offers queued pixel words. Idles at random about 29% of the time,
  // except for a stretch of back-to-back words in the middle of the run.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_escapes.push_back(predict_escape(pixel));
      end
      // a word still waiting for busy to drop stays on the port untouched
      if (!start || !busy) begin
        if (pending_pixels.size() != 0 &&
            ((words_sent >= 200 && words_sent < 400) || $urandom_range(0, 99) >= 29)) begin
          start <= 1'b1;
          pixel <= pending_pixels.pop_front();
          words_sent++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results come as one-cycle strobes and cannot be held off.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_escapes.size() == 0) begin
        if (bad_words < MAX_REPORTS)
          $display("%0t: result word with none pending: x=%0d y=%0d n=%0d", $realtime,
                   result.screen_x, result.screen_y, result.escape_count);
        bad_words++;
      end else begin
        want = expected_escapes.pop_front();
        if (result.screen_x !== want.screen_x || result.screen_y !== want.screen_y ||
            result.escape_count !== want.escape_count) begin
          if (bad_words < MAX_REPORTS)
            $display("%0t: escape word mismatch: want x=%0d y=%0d n=%0d got x=%0d y=%0d n=%0d",
                     $realtime, want.screen_x, want.screen_y, want.escape_count,
                     result.screen_x, result.screen_y, result.escape_count);
          bad_words++;
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    case (idx)
      met_pkg::IDX_RE_START:    window_cfg.re_start = data;
      met_pkg::IDX_IM_START:    window_cfg.im_start = data;
      met_pkg::IDX_RE_STEP:     window_cfg.re_step = data;
      met_pkg::IDX_IM_STEP:     window_cfg.im_step = data;
      met_pkg::IDX_MAX_ITER:    window_cfg.max_iterations = data[15:0];
      met_pkg::IDX_WINDOW_LEFT: window_cfg.window_left = data[11:0];
      met_pkg::IDX_WINDOW_TOP:  window_cfg.window_top = data[11:0];
      default: ;
    endcase
  endtask

  task automatic program_window(input logic [31:0] re0, im0, dre, dim, limit, left, top);
    write_reg(met_pkg::IDX_RE_START, re0);
    write_reg(met_pkg::IDX_IM_START, im0);
    write_reg(met_pkg::IDX_RE_STEP, dre);
    write_reg(met_pkg::IDX_IM_STEP, dim);
    write_reg(met_pkg::IDX_MAX_ITER, limit);
    write_reg(met_pkg::IDX_WINDOW_LEFT, left);
    write_reg(met_pkg::IDX_WINDOW_TOP, top);
    @(posedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // hold the sender until the block is idle and every result is in
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || start || busy || expected_escapes.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic queue_pixel(input int col, input int row);
    met_pkg::pixel_t px;
    px.column = col[11:0];
    px.row = row[11:0];
    pending_pixels.push_back(px);
  endtask

  // One random window: mostly a view that covers the set so counts spread out,
  // sometimes raw register values. Dirty upper bits test the narrow registers.
  task automatic run_random_phase(input int n_words);
    logic [31:0] re0, im0, dre, dim;
    logic [15:0] limit;
    int          jitter;
    case ($urandom_range(0, 3))
      0:       limit = 16'($urandom_range(1, 8));
      1, 2:    limit = 16'($urandom_range(9, 64));
      default: limit = 16'($urandom_range(65, 255));
    endcase
    if ($urandom_range(0, 9) == 0) begin
      re0 = $urandom;
      im0 = $urandom;
      dre = $urandom;
      dim = $urandom;
    end else begin
      dre = $urandom_range(20000, 300000);
      dim = $urandom_range(20000, 300000);
      jitter = int'($urandom_range(0, 1 << 28)) - (1 << 27);
      re0 = 32'(-671088640 + jitter);
      jitter = int'($urandom_range(0, 1 << 28)) - (1 << 27);
      im0 = 32'(-402653184 + jitter);
      // walk right-to-left or bottom-to-top now and then
      if ($urandom_range(0, 3) == 0) begin
        dre = -dre;
        re0 = re0 + 32'd939524096;
      end
      if ($urandom_range(0, 3) == 0) begin
        dim = -dim;
        im0 = -im0;
      end
    end
    program_window(re0, im0, dre, dim, {16'($urandom), limit},
                   {20'($urandom), 12'($urandom)}, {20'($urandom), 12'($urandom)});
    for (int i = 0; i < n_words; i++)
      queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default window after reset: corners, alternating bits, and a point
    // right at the origin that never escapes
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(0, 4095);
    queue_pixel(4095, 0);
    queue_pixel(12'hAAA, 12'h555);
    queue_pixel(12'h555, 12'hAAA);
    queue_pixel(200, 120);
    queue_pixel(160, 100);
    wait_drained();

    // c = 3.0 with a limit of one: escapes on the last allowed step
    program_window(32'sd805306368, 32'd0, 32'd0, 32'd0, 32'd1, 32'd4095, 32'd4095);
    queue_pixel(4095, 4095);
    queue_pixel(17, 3000);
    wait_drained();

    // c = 1.5, limit two: |z|^2 = 2.25 then 14.06, escape exactly at the limit
    program_window(32'sd402653184, 32'd0, 32'd0, 32'd0, 32'd2, 32'd0, 32'd4095);
    queue_pixel(4095, 0);
    wait_drained();

    // zero limit always reports 0; a write to an unused index must change nothing
    program_window(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd2);
    write_reg(IDX_UNUSED, 32'hFFFF_FFFF);
    @(posedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    wait_drained();

    // register extremes: largest steps and starts, top limit, far window origin
    program_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'd65535, 32'd4095, 32'd4095);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    wait_drained();
    program_window(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'd65535, 32'd0, 32'd0);
    queue_pixel(4095, 4095);
    queue_pixel(1, 1);
    wait_drained();

    // c = 0 at the top limit: the full 65536-step run, count 0
    program_window(32'd0, 32'd0, 32'd0, 32'd0, 32'd65535, 32'd0, 32'd0);
    queue_pixel(2048, 2048);
    wait_drained();

    // random windows; each phase ends with the sender held until all is back
    for (int p = 0; p < 8; p++)
      run_random_phase(100);

    repeat (20) @(posedge clk);
    if (bad_words == 0 && expected_escapes.size() == 0) begin
      $display("mandelbrot_escape_time verification clean");
    end else begin
      $display("mandelbrot_escape_time verification failed");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #20_000_000;
    $display("mandelbrot_escape_time verification failed");
    $finish;
  end

endmodule
